// File: sv/b58_pkg.sv
package b58_pkg;

    // Fixed figures of the Base58 conversion
    localparam int unsigned BASE      = 58;
    localparam int unsigned MAX_CHARS = 59;
    localparam int unsigned DIG_DEPTH = 64;
    localparam int unsigned DIG_AW    = 6;
    // floor(2^16 / 58): quotient estimate is low by at most one
    localparam int unsigned RECIP     = 1129;
    localparam logic [6:0]  CHAR_ONE  = 7'd49;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    typedef logic [DIG_AW-1:0] digit_t;

    // Base58 digit to ASCII; gaps skip 0, I, O and l
    function automatic logic [6:0] b58_char(input digit_t d);
        logic [6:0] c;
        case (d) inside
            [6'd0:6'd8]:   c = 7'd49 + 7'(d);
            [6'd9:6'd16]:  c = 7'd56 + 7'(d);
            [6'd17:6'd21]: c = 7'd57 + 7'(d);
            [6'd22:6'd32]: c = 7'd58 + 7'(d);
            [6'd33:6'd43]: c = 7'd64 + 7'(d);
            [6'd44:6'd57]: c = 7'd65 + 7'(d);
            default:       c = CHAR_ONE;
        endcase
        return c;
    endfunction

endpackage

// File: sv/b58_ram.sv
module b58_ram
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 43
)
(
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/b58_div58.sv
module b58_div58
    import b58_pkg::*;
(
    input  digit_t     rem_in,
    input  logic [7:0] byte_in,
    output logic [7:0] quot,
    output digit_t     rem_out
);

    logic [13:0] acc;
    logic [24:0] prod;
    logic [7:0]  q_est;
    logic [13:0] r_est;

    // Reciprocal estimate, then one correction step
    always_comb
    begin
        acc   = {rem_in, byte_in};
        prod  = 25'(acc) * 25'(RECIP);
        q_est = prod[23:16];
        r_est = acc - 14'(q_est) * 14'(BASE);
        if (r_est >= 14'(BASE))
        begin
            quot    = q_est + 8'd1;
            rem_out = 6'(r_est - 14'(BASE));
        end
        else
        begin
            quot    = q_est;
            rem_out = r_est[5:0];
        end
    end

endmodule

// File: sv/base58_payload_encoder_core.sv
// Base58 payload encoder. Payload bytes come in one request each, most
// significant first; final_byte closes the payload. Each byte is stored as
// it is taken (up to MAX_BYTES bytes; further bytes are dropped and flag
// overflow on every character of that payload). After the final byte the
// stored number is divided by 58 in place, one stored byte per cycle through
// a single divide-by-58 unit around the byte RAM; each pass over the
// remaining bytes yields one output digit. Digits land in a small digit RAM
// and are then sent most significant first, preceded by one '1' per leading
// zero byte, each character read from the digit RAM and then loaded into
// the output register once that is free; at most 59 characters, the
// last one marked with final_char. No new byte is taken during conversion
// and emission, but the next payload may start while the last character
// still waits in the output register.
module base58_payload_encoder_core
    import b58_pkg::*;
#(
    parameter int unsigned MAX_BYTES = 43
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] char_code,
    output logic       final_char,
    output logic       overflow
);

    localparam int unsigned CW = $clog2(MAX_BYTES + 1);
    localparam int unsigned AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    state_t state_reg, state_next;

    // Payload accumulation
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lz_reg, lz_next;
    logic          seen_nz_reg, seen_nz_next;
    logic          ovf_reg, ovf_next;

    // Division pass control
    logic [CW-1:0] start_reg, start_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          d_vld_reg, d_vld_next;
    logic [CW-1:0] d_idx_reg, d_idx_next;
    digit_t        rem_reg, rem_next;
    digit_t        nd_reg, nd_next;

    // Emission control
    logic [CW-1:0] ones_reg, ones_next;
    digit_t        dl_reg, dl_next;
    digit_t        em_reg, em_next;

    // Output register
    logic          out_valid_reg, out_valid_next;
    logic [6:0]    out_char_reg, out_char_next;
    logic          out_final_reg, out_final_next;
    logic          out_ovf_reg, out_ovf_next;

    // RAM ports
    logic          num_we;
    logic [AW-1:0] num_waddr;
    logic [7:0]    num_wdata;
    logic [AW-1:0] num_raddr;
    logic [7:0]    num_rdata;
    logic          dig_we;
    digit_t        dig_rdata;
    digit_t        dig_raddr;

    // Datapath helpers
    logic          in_acc;
    logic          store;
    logic          issue;
    logic          pass_end;
    logic          div_done;
    logic          emit_load;
    logic          emit_last;
    logic [CW-1:0] lz_new;
    logic [CW-1:0] start_upd;
    logic [7:0]    div_q;
    digit_t        div_r;

    assign in_acc    = in_valid && in_ready;
    assign store     = count_reg < CW'(MAX_BYTES);
    assign issue     = (state_reg == S_DIV) && (rd_idx_reg < count_reg);
    assign pass_end  = d_vld_reg && (d_idx_reg == count_reg - CW'(1));
    assign div_done  = !d_vld_reg && !(rd_idx_reg < count_reg);
    assign emit_load = (state_reg == S_EMIT_LD) && (!out_valid_reg || out_ready);

    // Last character: cap reached, or nothing left after this one
    always_comb
    begin
        if (em_reg == DIG_AW'(MAX_CHARS - 1))
        begin
            emit_last = 1'b1;
        end
        else if (ones_reg != '0)
        begin
            emit_last = (ones_reg == CW'(1)) && (dl_reg == '0);
        end
        else
        begin
            emit_last = (dl_reg == DIG_AW'(1));
        end
    end

    b58_div58 u_div
    (
        .rem_in  (rem_reg),
        .byte_in (num_rdata),
        .quot    (div_q),
        .rem_out (div_r)
    );

    b58_ram
    #(
        .WIDTH (8),
        .DEPTH (MAX_BYTES)
    )
    u_num_ram
    (
        .clk   (clk),
        .we    (num_we),
        .waddr (num_waddr),
        .wdata (num_wdata),
        .raddr (num_raddr),
        .rdata (num_rdata)
    );

    b58_ram
    #(
        .WIDTH (DIG_AW),
        .DEPTH (DIG_DEPTH)
    )
    u_dig_ram
    (
        .clk   (clk),
        .we    (dig_we),
        .waddr (nd_reg),
        .wdata (div_r),
        .raddr (dig_raddr),
        .rdata (dig_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && final_byte)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (emit_load)
                begin
                    state_next = emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Handshake and RAM controls
    always_comb
    begin
        in_ready  = 1'b0;
        num_we    = 1'b0;
        num_waddr = d_idx_reg[AW-1:0];
        num_wdata = div_q;
        dig_we    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                num_we    = in_acc && store;
                num_waddr = count_reg[AW-1:0];
                num_wdata = data_byte;
            end
            S_DIV:
            begin
                num_we = d_vld_reg;
                dig_we = pass_end;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        num_raddr = rd_idx_reg[AW-1:0];
        dig_raddr = dl_reg - DIG_AW'(1);
    end

    // Leading zero count including the byte being taken
    always_comb
    begin
        lz_new = lz_reg;
        if (store && (data_byte == 8'd0) && !seen_nz_reg)
        begin
            lz_new = lz_reg + CW'(1);
        end
    end

    // The top quotient byte can drop to zero at most once per pass
    assign start_upd = (d_vld_reg && (d_idx_reg == start_reg) && (div_q == 8'd0))
                       ? start_reg + CW'(1) : start_reg;

    // Datapath next values
    always_comb
    begin
        count_next     = count_reg;
        lz_next        = lz_reg;
        seen_nz_next   = seen_nz_reg;
        ovf_next       = ovf_reg;
        start_next     = start_reg;
        rd_idx_next    = rd_idx_reg;
        d_vld_next     = 1'b0;
        d_idx_next     = d_idx_reg;
        rem_next       = rem_reg;
        nd_next        = nd_reg;
        ones_next      = ones_reg;
        dl_next        = dl_reg;
        em_next        = em_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_char_next  = out_char_reg;
        out_final_next = out_final_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (store)
                    begin
                        count_next = count_reg + CW'(1);
                        lz_next    = lz_new;
                        if (data_byte != 8'd0)
                        begin
                            seen_nz_next = 1'b1;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    // Conversion starts past the leading zero bytes
                    start_next  = lz_new;
                    rd_idx_next = lz_new;
                    rem_next    = '0;
                    nd_next     = '0;
                end
            end
            S_DIV:
            begin
                d_vld_next = issue;
                d_idx_next = rd_idx_reg;
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                if (d_vld_reg)
                begin
                    rem_next   = div_r;
                    start_next = start_upd;
                end
                if (pass_end)
                begin
                    rd_idx_next = start_upd;
                    rem_next    = '0;
                    nd_next     = nd_reg + DIG_AW'(1);
                end
                if (div_done)
                begin
                    ones_next = lz_reg;
                    dl_next   = nd_reg;
                    em_next   = '0;
                end
            end
            S_EMIT_LD:
            begin
                if (emit_load)
                begin
                    out_valid_next = 1'b1;
                    out_final_next = emit_last;
                    out_ovf_next   = ovf_reg;
                    em_next        = em_reg + DIG_AW'(1);
                    if (ones_reg != '0)
                    begin
                        out_char_next = CHAR_ONE;
                        ones_next     = ones_reg - CW'(1);
                    end
                    else
                    begin
                        out_char_next = b58_char(dig_rdata);
                        dl_next       = dl_reg - DIG_AW'(1);
                    end
                    if (emit_last)
                    begin
                        count_next   = '0;
                        lz_next      = '0;
                        seen_nz_next = 1'b0;
                        ovf_next     = 1'b0;
                    end
                end
            end
            default:
            begin
                d_vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            lz_reg        <= '0;
            seen_nz_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            start_reg     <= '0;
            rd_idx_reg    <= '0;
            d_vld_reg     <= 1'b0;
            d_idx_reg     <= '0;
            rem_reg       <= '0;
            nd_reg        <= '0;
            ones_reg      <= '0;
            dl_reg        <= '0;
            em_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_final_reg <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lz_reg        <= lz_next;
            seen_nz_reg   <= seen_nz_next;
            ovf_reg       <= ovf_next;
            start_reg     <= start_next;
            rd_idx_reg    <= rd_idx_next;
            d_vld_reg     <= d_vld_next;
            d_idx_reg     <= d_idx_next;
            rem_reg       <= rem_next;
            nd_reg        <= nd_next;
            ones_reg      <= ones_next;
            dl_reg        <= dl_next;
            em_reg        <= em_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_final_reg <= out_final_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign char_code  = out_char_reg;
    assign final_char = out_final_reg;
    assign overflow   = out_ovf_reg;

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

// Testbench for the Base58 payload encoder.
// Payload bytes go in one request each; the encoded characters come back one
// request each. An in-bench model of the encoder keeps its own copy of the
// stored number, the leading-zero count and the drop flag, and works out the
// characters every final byte should produce. Each returned character is
// checked field by field against the oldest one still owed.
module tb;

    localparam int unsigned BUF_BYTES     = 43;
    localparam int unsigned MAX_ENC_CHARS = 59;
    localparam int unsigned RADIX         = 58;
    localparam int unsigned RANDOM_REQS   = 300;
    localparam int unsigned HOLD_CYCLES   = 800;
    // quiet time after the last owed character, for any stray one to show
    localparam int unsigned DRAIN_CYCLES  = 200;
    localparam int unsigned CYCLE_LIMIT   = 400_000;

    // Base58 alphabet, digit 0 in the top byte
    localparam logic [8*58-1:0] B58_DIGITS =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    typedef struct packed {
        logic [6:0] code;
        logic       last;
        logic       ovf;
    } enc_char_t;

    // Directed row: reps copies of byte_val, last flag on the final copy only.
    // chars holds up to three expected characters typed in by hand; zero
    // means the in-bench model supplies them.
    typedef struct packed {
        logic [7:0]  byte_val;
        logic        last;
        logic [5:0]  reps;
        logic [23:0] chars;
    } dir_row_t;

    localparam int unsigned DIR_ROWS = 16;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{8'h00, 1'b1, 6'd1,  "1"},    // single zero byte: only a '1'
        '{8'h01, 1'b1, 6'd1,  "2"},
        '{8'h39, 1'b1, 6'd1,  "z"},    // 57, top digit
        '{8'h3A, 1'b1, 6'd1,  "21"},   // 58, first carry
        '{8'h00, 1'b0, 6'd2,  24'd0},
        '{8'h01, 1'b1, 6'd1,  "112"},  // two leading zeros then a digit
        '{8'h00, 1'b0, 6'd1,  24'd0},
        '{8'h00, 1'b1, 6'd1,  "11"},   // all-zero payload
        '{8'hFF, 1'b1, 6'd1,  24'd0},
        '{8'h80, 1'b0, 6'd1,  24'd0},
        '{8'h7F, 1'b0, 6'd1,  24'd0},
        '{8'hAA, 1'b0, 6'd1,  24'd0},
        '{8'h55, 1'b1, 6'd1,  24'd0},
        '{8'h00, 1'b0, 6'd1,  24'd0},
        '{8'hFF, 1'b0, 6'd44, 24'd0},  // fills the buffer, two bytes dropped
        '{8'h00, 1'b1, 6'd1,  24'd0}   // dropped too, still closes payload
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       final_byte;
    logic       out_valid;
    logic       out_ready;
    logic [6:0] char_code;
    logic       final_char;
    logic       overflow;

    // In-bench model state
    logic [7:0]  held_bytes [BUF_BYTES];
    int unsigned held_count;
    int unsigned lead_zeros;
    bit          nonzero_seen;
    bit          bytes_dropped;

    enc_char_t   fresh_chars [$];   // characters of the payload just closed
    enc_char_t   owed_chars [$];    // characters still to come from the block

    int unsigned send_idle_pct;
    int unsigned stall_pct;
    bit          hold_req;
    int unsigned mismatches;
    int unsigned cycle_cnt;

    base58_payload_encoder_core #(.MAX_BYTES(BUF_BYTES)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .char_code  (char_code),
        .final_char (final_char),
        .overflow   (overflow)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Store one accepted byte; on the last byte, divide the stored number by
    // 58 again and again and build the character list in fresh_chars.
    function automatic void b58_absorb(input logic [7:0] b, input logic last);
        logic [7:0]  work [BUF_BYTES];
        logic [5:0]  rev [$];
        int unsigned start;
        int unsigned rem;
        int unsigned accv;
        int unsigned total;
        int unsigned d;
        enc_char_t   c;

        fresh_chars.delete();
        if (held_count < BUF_BYTES)
        begin
            held_bytes[held_count] = b;
            held_count++;
            if (b != 8'd0)
                nonzero_seen = 1'b1;
            else if (!nonzero_seen)
                lead_zeros++;
        end
        else
            bytes_dropped = 1'b1;

        if (!last)
            return;

        work  = held_bytes;
        start = 0;
        while (start < held_count && work[start] == 8'd0)
            start++;
        while (start < held_count)
        begin
            rem = 0;
            for (int unsigned i = start; i < held_count; i++)
            begin
                accv    = (rem << 8) | work[i];
                work[i] = 8'(accv / RADIX);
                rem     = accv % RADIX;
            end
            rev.insert(rev.size(), 6'(rem));
            while (start < held_count && work[start] == 8'd0)
                start++;
        end

        total = lead_zeros + rev.size();
        if (total > MAX_ENC_CHARS)
            total = MAX_ENC_CHARS;
        for (int unsigned k = 0; k < total; k++)
        begin
            d      = (k < lead_zeros) ? 0 : rev[rev.size() - 1 - (k - lead_zeros)];
            c.code = B58_DIGITS[8 * (57 - d) +: 7];
            c.last = (k + 1 == total);
            c.ovf  = bytes_dropped;
            fresh_chars.insert(fresh_chars.size(), c);
        end

        held_count    = 0;
        lead_zeros    = 0;
        nonzero_seen  = 1'b0;
        bytes_dropped = 1'b0;
    endfunction

    // Offer one byte request; called and returning at a falling edge.
    task automatic offer_byte(input logic [7:0] b, input logic last,
                              input logic [23:0] typed);
        enc_char_t c;
        int unsigned n;

        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        final_byte <= last;
        do
            @(posedge clk);
        while (!in_ready);
        b58_absorb(b, last);
        if (last && typed != 24'd0)
        begin
            // hand-typed characters stand in for the model's own
            n = 0;
            for (int i = 2; i >= 0; i--)
                if (typed[8*i +: 8] != 8'd0)
                    n++;
            for (int i = 2; i >= 0; i--)
            begin
                if (typed[8*i +: 8] != 8'd0)
                begin
                    n--;
                    c.code = typed[8*i +: 7];
                    c.last = (n == 0);
                    c.ovf  = 1'b0;
                    owed_chars.insert(owed_chars.size(), c);
                end
            end
        end
        else
            foreach (fresh_chars[k])
                owed_chars.insert(owed_chars.size(), fresh_chars[k]);
        @(negedge clk);
    endtask

    // Idle pattern for both sides: none, sender only, receiver only, both.
    task automatic set_phase(input int unsigned p);
        case (p)
            0:
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            1:
            begin
                send_idle_pct = 53;
                stall_pct     = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct     = 53;
            end
            default:
            begin
                send_idle_pct = 37;
                stall_pct     = 37;
            end
        endcase
    endtask

    // Receiver: random stalls, plus one long hold-off counted here while
    // the sender keeps offering, so the block backs up into its input.
    initial
    begin : recv_side
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Character checker
    always @(posedge clk)
    begin
        enc_char_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_chars.size() == 0)
            begin
                $error("unexpected character: char_code %0d final_char %0b overflow %0b",
                       char_code, final_char, overflow);
                mismatches++;
            end
            else
            begin
                want = owed_chars.pop_front();
                if (char_code !== want.code)
                begin
                    $error("char_code: expected %0d, got %0d", want.code, char_code);
                    mismatches++;
                end
                if (final_char !== want.last)
                begin
                    $error("final_char: expected %0b, got %0b", want.last, final_char);
                    mismatches++;
                end
                if (overflow !== want.ovf)
                begin
                    $error("overflow: expected %0b, got %0b", want.ovf, overflow);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin : watchdog
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("FAIL base58_payload_encoder_core");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned random_reqs;
        int unsigned pl;
        int unsigned len;
        int unsigned lz;
        int unsigned mode;
        int unsigned pick;
        logic [7:0]  b;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = 8'd0;
        final_byte    = 1'b0;
        out_ready     = 1'b0;
        hold_req      = 1'b0;
        mismatches    = 0;
        cycle_cnt     = 0;
        held_count    = 0;
        lead_zeros    = 0;
        nonzero_seen  = 1'b0;
        bytes_dropped = 1'b0;
        foreach (held_bytes[i])
            held_bytes[i] = 8'd0;
        set_phase(0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part
        foreach (dir_rows[r])
            for (int unsigned k = 0; k < dir_rows[r].reps; k++)
                offer_byte(dir_rows[r].byte_val,
                           dir_rows[r].last && (k + 1 == dir_rows[r].reps),
                           dir_rows[r].chars);

        // Random payloads: mostly short, some filling the buffer exactly,
        // some spilling over it; contents random, all zero, all ones or
        // opening with a run of zeros.
        random_reqs = 0;
        pl          = 0;
        while (random_reqs < RANDOM_REQS)
        begin
            set_phase((pl / 6) % 4);
            if (pl == 9)
                hold_req = 1'b1;
            pick = $urandom_range(99);
            if (pick < 60)
                len = $urandom_range(6, 1);
            else if (pick < 78)
                len = $urandom_range(20, 7);
            else if (pick < 86)
                len = $urandom_range(42, 21);
            else if (pick < 92)
                len = BUF_BYTES;
            else
                len = $urandom_range(BUF_BYTES + 7, BUF_BYTES + 1);
            mode = $urandom_range(9);
            lz   = (mode == 2) ? $urandom_range(len, 1) : 0;
            for (int unsigned i = 0; i < len; i++)
            begin
                case (mode)
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = (i < lz) ? 8'h00 : 8'($urandom_range(255));
                endcase
                offer_byte(b, i + 1 == len, 24'd0);
            end
            random_reqs += len;
            pl++;
        end
        in_valid <= 1'b0;

        while (owed_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS base58_payload_encoder_core");
        else
            $display("FAIL base58_payload_encoder_core");
        $finish;
    end

endmodule
